### src/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg: shared constants and functions of the SHA-256 stream hasher
// Round constants, initial chaining values and the round helper functions.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned Rounds     = 64;
    localparam int unsigned DigestWords = 8;

    typedef logic [31:0] t_word;

    localparam t_word INIT_H [DigestWords] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word ROUND_K [Rounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word rotr(input t_word v, input int unsigned n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    function automatic t_word sig0(input t_word x);
        sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word sig1(input t_word x);
        sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word bsig0(input t_word x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word bsig1(input t_word x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

### src/sha_if.sv
// ----------------------------------------------------------------------------
// sha_in_if / sha_out_if: byte input and digest output channels
// Valid/ready channels carrying the hasher payloads.
// ----------------------------------------------------------------------------
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
    modport source (output valid, data_byte, has_byte, is_last, input ready);
    modport sink   (input valid, data_byte, has_byte, is_last, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

### src/sha256_stream_hasher_top.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top: byte-serial SHA-256 hasher
// Collects message bytes into 32-bit words in a schedule memory, compresses
// each 64-byte block with one round per cycle and emits the digest words.
// ----------------------------------------------------------------------------
// A beat that neither completes a block nor is last is taken without
// leaving the fill state, so such beats can follow back to back. The byte
// that completes a block starts a compression: a load of the sixteen words
// into the schedule window (a prime of the registered read, then sixteen
// shifts), 64 rounds at one per cycle and a fold into the chaining state,
// in all of which no beat is taken. A last beat pads in place, word by word
// from the word that takes the 0x80 marker up to word 15, then compresses.
// When 56 or more bytes are held, or when the last byte itself completes a
// block, a second block follows: all sixteen words are padded and the block
// is compressed in the same way. The eight digest words then go out one per
// cycle as the sink takes them; input stays stalled until the last of them
// is taken. The message words live in a 16-entry memory of 32-bit words with
// a registered read, the expanded schedule in a window; the round loop reads
// w[t-16], w[t-15], w[t-7] and w[t-2] from registered copies of the last
// sixteen words.
module sha256_stream_hasher_top
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    sha_in_if.sink      i_in,
    sha_out_if.source   o_out
);

    typedef enum logic [2:0] {
        ST_FILL, ST_PAD, ST_LOAD, ST_ROUND, ST_FOLD, ST_EMIT
    } t_state;

    t_state       r_state;
    logic [31:0]  r_mem [16];
    logic [31:0]  r_win [16];      // sliding schedule window, w[t-16]..w[t-1]
    logic [31:0]  r_acc;           // word being assembled
    logic [5:0]   r_fill;          // bytes held in current block
    logic [60:0]  r_len;
    logic [31:0]  r_h [8];
    logic [31:0]  r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_hh;
    logic [5:0]   r_rnd;
    logic [4:0]   r_ld;            // load counter over memory
    logic [3:0]   r_pw;            // pad word index
    logic         r_fin;           // finishing a message
    logic         r_lenblk;        // current pad block carries the length
    logic         r_mark;          // marker still to go into the next pad block
    logic [2:0]   r_oi;
    logic [31:0]  r_rd;

    assign i_in.ready = (r_state == ST_FILL);
    wire in_acc = i_in.valid && i_in.ready;

    // bytes held once this beat is taken
    logic [5:0] fill_next;
    assign fill_next = r_fill + {5'd0, i_in.has_byte};

    // schedule word for the current round from the window
    logic [31:0] w_t;
    always_comb begin
        if (r_rnd < 6'd16) begin
            w_t = r_win[0];
        end else begin
            w_t = r_win[0] + sig0(r_win[1]) + r_win[9] + sig1(r_win[14]);
        end
    end

    // padded word content for word index r_pw
    logic [31:0] pad_w;
    logic [3:0]  cur_w;
    logic [1:0]  cur_b;
    assign cur_w = r_fill[5:2];
    assign cur_b = r_fill[1:0];
    always_comb begin
        pad_w = 32'd0;
        if (r_mark && r_pw == cur_w) begin
            unique case (cur_b)
                2'd0: pad_w = 32'h8000_0000;
                2'd1: pad_w = {r_acc[31:24], 24'h800000};
                2'd2: pad_w = {r_acc[31:16], 16'h8000};
                2'd3: pad_w = {r_acc[31:8], 8'h80};
                default: pad_w = 32'd0;
            endcase
        end else if (r_lenblk && r_pw == 4'd14) begin
            pad_w = r_len[60:29];
        end else if (r_lenblk && r_pw == 4'd15) begin
            pad_w = {r_len[28:0], 3'b000};
        end
    end

    logic [31:0] t1, t2;
    assign t1 = r_hh + bsig1(r_e) + ((r_e & r_f) ^ (~r_e & r_g)) + ROUND_K[r_rnd] + w_t;
    assign t2 = bsig0(r_a) + ((r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c));

    // memory write in fill and pad, read in load
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.has_byte && cur_b == 2'd3) begin
            r_mem[cur_w] <= {r_acc[31:8], i_in.data_byte};
        end else if (r_state == ST_PAD) begin
            r_mem[r_pw] <= pad_w;
        end
        r_rd <= r_mem[r_ld[3:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
            r_fill <= '0;
            r_len <= '0;
            r_fin <= 1'b0;
            r_mark <= 1'b0;
            r_lenblk <= 1'b0;
            r_oi <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= INIT_H[i];
        end else begin
            unique case (r_state)
                ST_FILL: begin
                    if (in_acc) begin
                        if (i_in.has_byte) begin
                            r_len <= r_len + 61'd1;
                            r_fill <= fill_next;
                            unique case (cur_b)
                                2'd0: r_acc[31:24] <= i_in.data_byte;
                                2'd1: r_acc[23:16] <= i_in.data_byte;
                                2'd2: r_acc[15:8] <= i_in.data_byte;
                                2'd3: r_acc[7:0] <= i_in.data_byte;
                                default: ;
                            endcase
                        end
                        if (i_in.has_byte && r_fill == 6'd63) begin
                            // full block: compress, pad block follows on a last beat
                            r_fin <= i_in.is_last;
                            r_mark <= 1'b1;
                            r_lenblk <= 1'b0;
                            r_ld <= '0;
                            r_state <= ST_LOAD;
                        end else if (i_in.is_last) begin
                            // pad from the word that takes the marker
                            r_fin <= 1'b1;
                            r_mark <= 1'b1;
                            r_lenblk <= (fill_next < 6'd56);
                            r_pw <= fill_next[5:2];
                            r_state <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    r_pw <= r_pw + 4'd1;
                    if (r_pw == 4'd15) begin
                        r_mark <= 1'b0;
                        r_ld <= '0;
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    // prime one read, then shift sixteen words into window
                    r_ld <= r_ld + 5'd1;
                    if (r_ld != 5'd0) begin
                        for (int i = 0; i < 15; i++) r_win[i] <= r_win[i+1];
                        r_win[15] <= r_rd;
                    end
                    if (r_ld == 5'd16) begin
                        r_state <= ST_ROUND;
                        r_rnd <= '0;
                        r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2]; r_d <= r_h[3];
                        r_e <= r_h[4]; r_f <= r_h[5]; r_g <= r_h[6]; r_hh <= r_h[7];
                    end
                end
                ST_ROUND: begin
                    r_hh <= r_g; r_g <= r_f; r_f <= r_e; r_e <= r_d + t1;
                    r_d <= r_c; r_c <= r_b; r_b <= r_a; r_a <= t1 + t2;
                    for (int i = 0; i < 15; i++) r_win[i] <= r_win[i+1];
                    r_win[15] <= w_t;
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) r_state <= ST_FOLD;
                end
                ST_FOLD: begin
                    r_h[0] <= r_h[0] + r_a; r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c; r_h[3] <= r_h[3] + r_d;
                    r_h[4] <= r_h[4] + r_e; r_h[5] <= r_h[5] + r_f;
                    r_h[6] <= r_h[6] + r_g; r_h[7] <= r_h[7] + r_hh;
                    r_fill <= '0;
                    if (!r_fin) begin
                        r_state <= ST_FILL;
                    end else if (r_lenblk) begin
                        r_oi <= '0;
                        r_state <= ST_EMIT;
                    end else begin
                        // one more block: marker if still owed, then the length
                        r_lenblk <= 1'b1;
                        r_pw <= '0;
                        r_state <= ST_PAD;
                    end
                end
                ST_EMIT: begin
                    if (o_out.ready) begin
                        r_oi <= r_oi + 3'd1;
                        if (r_oi == 3'd7) begin
                            r_state <= ST_FILL;
                            r_fill <= '0;
                            r_len <= '0;
                            r_fin <= 1'b0;
                            r_mark <= 1'b0;
                            r_lenblk <= 1'b0;
                            for (int i = 0; i < 8; i++) r_h[i] <= INIT_H[i];
                        end
                    end
                end
                default: r_state <= ST_FILL;
            endcase
        end
    end

    assign o_out.valid       = (r_state == ST_EMIT);
    assign o_out.digest_word = r_h[r_oi];
    assign o_out.word_index  = r_oi;
    assign o_out.last_word   = (r_oi == 3'd7);

    // digest output only while finishing
    a_emit_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> r_fin) else $error("emit without finish");
    // no byte taken during the rounds
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> !i_in.ready) else $error("ready during rounds");
    // round counter wraps back to fold
    a_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && r_rnd == 6'd63) |=> (r_state == ST_FOLD))
        else $error("round loop overrun");

endmodule
